[rtl/scba_pkg.sv]
// ----------------------------------------------------------------------------
// scba_pkg
// shared types, codes and constants of the size class block allocator
// ----------------------------------------------------------------------------
package scba_pkg;

  localparam int unsigned CHUNK_SIZE_DEF = 16384;
  localparam int unsigned MAX_CHUNKS_DEF = 16;

  localparam int unsigned NUM_CLASSES   = 14;
  localparam int unsigned CLS_W         = 4;
  localparam int unsigned SIZE_W        = 16;
  localparam int unsigned ADDR_W        = 18;
  localparam int unsigned GIDX_W        = 14;   // granule index of an 18-bit address
  localparam int unsigned BSIZE_W       = 10;
  localparam int unsigned LARGEST_BLOCK = 640;

  // opcodes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO     = 2'd1;
  localparam logic [1:0] ST_OVERSIZE = 2'd2;
  localparam logic [1:0] ST_NO_CHUNK = 2'd3;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_ALLOC,
    CMD_FREE,
    CMD_CLEAR
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_POP,
    BK_CARVE,
    BK_RESP
  } back_state_t;

  // classified request between front and back
  typedef struct packed {
    cmd_t              cmd;
    logic [1:0]        status;
    logic [CLS_W-1:0]  cls;
    logic [ADDR_W-1:0] addr;
    logic [GIDX_W-1:0] idx;
  } qentry_t;

  function automatic logic [BSIZE_W-1:0] class_size(input logic [CLS_W-1:0] k);
    logic [BSIZE_W-1:0] s;
    case (k)
      4'd0:    s = 10'd16;
      4'd1:    s = 10'd32;
      4'd2:    s = 10'd64;
      4'd3:    s = 10'd96;
      4'd4:    s = 10'd128;
      4'd5:    s = 10'd160;
      4'd6:    s = 10'd192;
      4'd7:    s = 10'd224;
      4'd8:    s = 10'd256;
      4'd9:    s = 10'd320;
      4'd10:   s = 10'd384;
      4'd11:   s = 10'd448;
      4'd12:   s = 10'd512;
      default: s = 10'd640;
    endcase
    return s;
  endfunction

endpackage

[rtl/scba_ram.sv]
// ----------------------------------------------------------------------------
// scba_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module scba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/scba_front.sv]
// ----------------------------------------------------------------------------
// scba_front
// accepts requests, picks the size class and the link index of a freed block
// ----------------------------------------------------------------------------
module scba_front import scba_pkg::*; #(
  parameter int unsigned CHUNK_SIZE = CHUNK_SIZE_DEF,
  parameter int unsigned MAX_CHUNKS = MAX_CHUNKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_opcode,
  input  logic [SIZE_W-1:0] in_size,
  input  logic [ADDR_W-1:0] in_addr,
  output logic              push_valid,
  input  logic              push_ready,
  output qentry_t           push_data
);

  localparam int unsigned LINK_DEPTH = (MAX_CHUNKS * CHUNK_SIZE) / 16;
  localparam int unsigned REC_SHIFT  = 28;
  localparam longint unsigned MUL_K  =
    ((64'd1 << REC_SHIFT) + 64'(LINK_DEPTH) - 64'd1) / 64'(LINK_DEPTH);
  localparam bit NEED_MOD = (LINK_DEPTH < (1 << GIDX_W));

  logic              v1_r, v2_r;
  qentry_t           e1_r, e2_r;
  logic [47:0]       prod_r;
  logic              adv1, adv2;
  qentry_t           e_new;
  qentry_t           e1_fix;
  logic [CLS_W-1:0]  cls;
  logic [19:0]       quo, qd, rem;
  logic [GIDX_W-1:0] gidx;

  assign adv2     = !v2_r || push_ready;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  // class = number of smaller block sizes below the request
  always_comb begin
    cls = '0;
    for (int k = 0; k < NUM_CLASSES - 1; k++) begin
      if (in_size > 16'(class_size(CLS_W'(k)))) begin
        cls = cls + 4'd1;
      end
    end
  end

  always_comb begin
    e_new        = '0;
    e_new.cls    = cls;
    e_new.addr   = in_addr;
    e_new.idx    = in_addr[ADDR_W-1:4];
    e_new.status = ST_OK;
    e_new.cmd    = CMD_NOP;
    if (in_opcode == OP_CLEAR) begin
      e_new.cmd = CMD_CLEAR;
    end else if (in_opcode == OP_NONE) begin
      e_new.cmd = CMD_NOP;
    end else if (in_size == '0) begin
      e_new.status = ST_ZERO;
    end else if (in_size > 16'(LARGEST_BLOCK)) begin
      e_new.status = ST_OVERSIZE;
    end else if (in_opcode == OP_ALLOC) begin
      e_new.cmd = CMD_ALLOC;
    end else begin
      e_new.cmd = CMD_FREE;
    end
  end

  // granule index modulo link depth by reciprocal multiply
  always_comb begin
    quo  = prod_r[47:REC_SHIFT];
    qd   = 20'(quo * 20'(LINK_DEPTH));
    rem  = 20'(e1_r.idx) - qd;
    if (rem >= 20'(LINK_DEPTH)) begin
      rem = rem - 20'(LINK_DEPTH);
    end
    gidx = NEED_MOD ? rem[GIDX_W-1:0] : e1_r.idx;
    e1_fix     = e1_r;
    e1_fix.idx = gidx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
    end
    if (adv1 && in_valid) begin
      e1_r   <= e_new;
      prod_r <= 48'(e_new.idx) * 48'(MUL_K);
    end
    if (adv2 && v1_r) begin
      e2_r <= e1_fix;
    end
  end

  assign push_valid = v2_r;
  assign push_data  = e2_r;

endmodule

[rtl/scba_queue.sv]
// ----------------------------------------------------------------------------
// scba_queue
// two-entry queue of classified requests between front and back
// ----------------------------------------------------------------------------
module scba_queue import scba_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  output logic    push_ready,
  input  qentry_t push_data,
  output logic    pop_valid,
  input  logic    pop_ready,
  output qentry_t pop_data
);

  qentry_t    slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = slot_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
    if (do_push) begin
      slot_r[wp_r] <= push_data;
    end
  end

endmodule

[rtl/scba_back.sv]
// ----------------------------------------------------------------------------
// scba_back
// carries out requests on the class heads and the link memory
// ----------------------------------------------------------------------------
module scba_back import scba_pkg::*; #(
  parameter int unsigned CHUNK_SIZE = CHUNK_SIZE_DEF,
  parameter int unsigned MAX_CHUNKS = MAX_CHUNKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  qentry_t           q_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] out_addr,
  output logic [1:0]        out_status
);

  localparam int unsigned LINK_DEPTH = (MAX_CHUNKS * CHUNK_SIZE) / 16;
  localparam int unsigned IDX_W      = $clog2(LINK_DEPTH);
  localparam int unsigned LW         = 1 + ADDR_W + IDX_W;
  localparam int unsigned RA_W       = $clog2(MAX_CHUNKS * CHUNK_SIZE + 1);
  localparam int unsigned OFF_W      = $clog2(CHUNK_SIZE) + 2;
  localparam int unsigned CU_W       = $clog2(MAX_CHUNKS + 1);

  back_state_t state_r, state_nxt;

  logic                  head_v_r [NUM_CLASSES];
  logic [ADDR_W-1:0]     head_a_r [NUM_CLASSES];
  logic [IDX_W-1:0]      head_i_r [NUM_CLASSES];
  logic [CU_W-1:0]       chunks_r;
  logic [RA_W-1:0]       base_r;
  logic [OFF_W-1:0]      off_r;
  logic [BSIZE_W-1:0]    bsize_r;
  logic [CLS_W-1:0]      cls_r;
  logic [ADDR_W-1:0]     res_addr_r;
  logic [1:0]            res_status_r;
  logic                  out_valid_r;
  logic [ADDR_W-1:0]     out_addr_r;
  logic [1:0]            out_status_r;

  logic                  ram_we, ram_re;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  logic [LW-1:0]         ram_wdata, ram_rdata;
  logic                  out_free, carve_more, no_chunk, head_hit;
  logic [RA_W:0]         here, nxt, first_next;
  logic [ADDR_W-1:0]     nxt_m, first_m;
  logic [IDX_W:0]        here_g;
  logic [BSIZE_W-1:0]    q_bsize;

  scba_ram #(.WIDTH(LW), .DEPTH(LINK_DEPTH)) u_link (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free   = !out_valid_r || out_ready;
  assign q_bsize    = class_size(q_data.cls);
  assign head_hit   = head_v_r[q_data.cls];
  assign no_chunk   = (chunks_r >= CU_W'(MAX_CHUNKS));
  assign here       = (RA_W+1)'(base_r) + (RA_W+1)'(off_r);
  assign nxt        = here + (RA_W+1)'(bsize_r);
  assign nxt_m      = ADDR_W'(nxt);
  assign carve_more = ((OFF_W+1)'(off_r) + (OFF_W+1)'({bsize_r, 1'b0}))
                      <= (OFF_W+1)'(CHUNK_SIZE);
  assign first_next = (RA_W+1)'(base_r) + (RA_W+1)'(q_bsize);
  assign first_m    = ADDR_W'(first_next);
  // granule index of a carved block, folded once when the depth is not exact
  assign here_g     = (here[IDX_W+4:4] >= (IDX_W+1)'(LINK_DEPTH)) ?
                      here[IDX_W+4:4] - (IDX_W+1)'(LINK_DEPTH) : here[IDX_W+4:4];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          if (q_data.cmd == CMD_ALLOC && head_hit) begin
            state_nxt = BK_POP;
          end else if (q_data.cmd == CMD_ALLOC && !no_chunk) begin
            state_nxt = BK_CARVE;
          end else begin
            state_nxt = BK_RESP;
          end
        end
      end
      BK_POP:   state_nxt = BK_RESP;
      BK_CARVE: if (!carve_more) state_nxt = BK_RESP;
      BK_RESP:  if (out_free) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_ready   = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = IDX_W'(q_data.idx);
    ram_raddr = head_i_r[q_data.cls];
    ram_wdata = {head_v_r[q_data.cls], head_a_r[q_data.cls], head_i_r[q_data.cls]};
    unique case (state_r)
      BK_IDLE: begin
        q_ready = 1'b1;
        ram_we  = q_valid && (q_data.cmd == CMD_FREE);
        ram_re  = q_valid && (q_data.cmd == CMD_ALLOC) && head_hit;
      end
      BK_CARVE: begin
        ram_we    = 1'b1;
        ram_waddr = here_g[IDX_W-1:0];
        ram_wdata = carve_more ? {1'b1, nxt_m, IDX_W'(nxt_m[ADDR_W-1:4])} : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      chunks_r    <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_CLASSES; k++) head_v_r[k] <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        BK_IDLE: if (q_valid) begin
          cls_r        <= q_data.cls;
          bsize_r      <= q_bsize;
          off_r        <= '0;
          res_addr_r   <= '0;
          res_status_r <= q_data.status;
          unique case (q_data.cmd)
            CMD_CLEAR: begin
              chunks_r <= '0;
              base_r   <= '0;
              for (int k = 0; k < NUM_CLASSES; k++) head_v_r[k] <= 1'b0;
            end
            CMD_FREE: begin
              head_v_r[q_data.cls] <= 1'b1;
              head_a_r[q_data.cls] <= q_data.addr;
              head_i_r[q_data.cls] <= IDX_W'(q_data.idx);
            end
            CMD_ALLOC: begin
              if (head_hit) begin
                res_addr_r <= head_a_r[q_data.cls];
              end else if (no_chunk) begin
                res_status_r <= ST_NO_CHUNK;
              end else begin
                res_addr_r <= ADDR_W'(base_r);
                chunks_r   <= chunks_r + CU_W'(1);
                head_v_r[q_data.cls] <= ((OFF_W)'({q_bsize, 1'b0}) <= OFF_W'(CHUNK_SIZE));
                head_a_r[q_data.cls] <= first_m;
                head_i_r[q_data.cls] <= IDX_W'(first_m[ADDR_W-1:4]);
              end
            end
            default: ;
          endcase
        end
        BK_POP: begin
          head_v_r[cls_r] <= ram_rdata[LW-1];
          head_a_r[cls_r] <= ram_rdata[LW-2:IDX_W];
          head_i_r[cls_r] <= ram_rdata[IDX_W-1:0];
        end
        BK_CARVE: begin
          off_r <= off_r + OFF_W'(bsize_r);
          if (!carve_more) base_r <= base_r + RA_W'(CHUNK_SIZE);
        end
        BK_RESP: if (out_free) begin
          out_addr_r   <= res_addr_r;
          out_status_r <= res_status_r;
        end
        default: ;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_addr   = out_addr_r;
  assign out_status = out_status_r;

endmodule

[rtl/size_class_block_allocator.sv]
// ----------------------------------------------------------------------------
// size_class_block_allocator
// segregated free list allocator over a region of fixed-size chunks
// ----------------------------------------------------------------------------
//
//  channel  direction  word contents (low bit up)
//  in_      slave      tuser: opcode[1:0]; tdata: req_size[15:0] free_addr[33:16]
//  out_     master     tdata: block_addr[17:0] status[19:18]
//
//  a request passes a two-stage classify pipe, a two-entry queue, then the
//  back sequencer; it goes from idle to response for free, clear and
//  rejected requests, through a pop state for a list pop, and through a
//  carve state, one link write per cycle, when a chunk is carved; a new
//  request is taken only in idle; the link memory read port is registered,
//  hence the pop state, and its contents need no clear
//  reset is synchronous, active low; all lists empty, no chunks used
//  input flows into the queue, until it is full, while a result waits on out_tready
//
module size_class_block_allocator import scba_pkg::*; #(
  parameter int unsigned CHUNK_SIZE = CHUNK_SIZE_DEF,
  parameter int unsigned MAX_CHUNKS = MAX_CHUNKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // req_size[15:0], free_addr[33:16], zero fill
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // block_addr[17:0], status[19:18], zero fill
);

  // front to queue
  logic    push_valid, push_ready;
  qentry_t push_data;
  // queue to back
  logic    pop_valid, pop_ready;
  qentry_t pop_data;
  // result fields
  logic [ADDR_W-1:0] res_addr;
  logic [1:0]        res_status;

  scba_front #(.CHUNK_SIZE(CHUNK_SIZE), .MAX_CHUNKS(MAX_CHUNKS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_opcode  (in_tuser),
    .in_size    (in_tdata[15:0]),
    .in_addr    (in_tdata[33:16]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  scba_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  scba_back #(.CHUNK_SIZE(CHUNK_SIZE), .MAX_CHUNKS(MAX_CHUNKS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (pop_valid),
    .q_ready    (pop_ready),
    .q_data     (pop_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_addr   (res_addr),
    .out_status (res_status)
  );

  // unused bits stay zero
  assign out_tdata = {4'd0, res_status, res_addr};

  // only a successful allocate carries an address
  a_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[17:0] != '0) |-> out_tdata[19:18] == ST_OK)
    else $error("nonzero block address with error status");

  // no result survives reset
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a stalled result word holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

endmodule
